### hdl/mwsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsg_pkg - shared definitions for the waveform sample generator
// Wave codes, register indexes, fixed-point constants, arctangent table
// and output saturation.
// ----------------------------------------------------------------------------
package mwsg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_FRAC  = SAMPLE_BITS - 1;
  localparam int CORDIC_FRAC  = 40;
  localparam int ROUND_SHIFT  = CORDIC_FRAC - SAMPLE_FRAC;

  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = DIVIDEND_W - DIVISOR_W;

  localparam int XY_W = 43;
  localparam int Z_W  = 34;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 43'sd667681663036;

  // wave codes
  localparam logic [2:0] WAVE_ZERO = 3'd0;
  localparam logic [2:0] WAVE_SIN  = 3'd1;
  localparam logic [2:0] WAVE_COS  = 3'd2;
  localparam logic [2:0] WAVE_RISE = 3'd3;
  localparam logic [2:0] WAVE_FALL = 3'd4;
  localparam logic [2:0] WAVE_TRI  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_WAVE   = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] t;
    case (k)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // clamp to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    hi = (64'sd1 <<< SAMPLE_FRAC) - 64'sd1;
    lo = -(64'sd1 <<< SAMPLE_FRAC);
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

### hdl/multi_waveform_sample_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_sample_generator_core - table sample generator
// Zero, sine, cosine, ramps and triangle in signed Q1.15 per input beat.
// ----------------------------------------------------------------------------
// Sequence: the zero wave goes straight from accept to the final state;
//   ramps/triangle first run the serial divider, and sine/cosine then
//   add a setup state and 16 CORDIC iterations after the divider.
// Throughput: one item at a time; a new beat is taken only back in idle.
//   A finished beat waits in the output register while the next runs.
// Reset: asynchronous, active low; registers go to sine, 256, 256 and the
//   phase and index counters clear.
// ----------------------------------------------------------------------------
module multi_waveform_sample_generator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mwsg_pkg::SAMPLE_BITS-1:0] sample_o,
  output logic [15:0]                           sample_index_o,
  output logic                                  last_of_table_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_CORD  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [2:0]  wave_q;
  logic [15:0] period_q, length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= mwsg_pkg::WAVE_SIN;
      period_q <= 16'd256;
      length_q <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        mwsg_pkg::REG_WAVE:   wave_q   <= pwdata[2:0];
        mwsg_pkg::REG_PERIOD: period_q <= pwdata[15:0];
        mwsg_pkg::REG_LENGTH: length_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mwsg_pkg::REG_WAVE:   prdata = {29'd0, wave_q};
      mwsg_pkg::REG_PERIOD: prdata = {16'd0, period_q};
      mwsg_pkg::REG_LENGTH: prdata = {16'd0, length_q};
      default:              prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;

  // phase and index bookkeeping at accept
  logic [15:0] phase_q, index_q;
  logic [15:0] n, pos, idx, p, len_m1;
  logic        last;
  logic [16:0] p_inc;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    n      = (period_q == 16'd0) ? 16'd1 : period_q;
    pos    = restart_i ? 16'd0 : phase_q;
    idx    = restart_i ? 16'd0 : index_q;
    p      = (pos < n) ? pos : 16'd0;
    len_m1 = length_q - 16'd1;
    last   = (idx == len_m1);
    p_inc  = {1'b0, p} + 17'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      index_q <= '0;
    end else if (accept) begin
      if (last) begin
        phase_q <= '0;
        index_q <= '0;
      end else begin
        index_q <= idx + 16'd1;
        phase_q <= (p_inc >= {1'b0, n}) ? 16'd0 : p_inc[15:0];
      end
    end
  end

  // ratio numerator and divider operand
  logic signed [18:0] twop, nn, rise, arise, num;
  logic [16:0]        mag;
  logic [mwsg_pkg::DIVIDEND_W-1:0] dividend;
  logic               is_trig, is_ratio;

  always_comb begin
    twop  = 19'(signed'({1'b0, p, 1'b0}));
    nn    = 19'(signed'({1'b0, n}));
    rise  = twop - nn;
    arise = rise[18] ? -rise : rise;
    case (wave_q)
      mwsg_pkg::WAVE_RISE: num = rise;
      mwsg_pkg::WAVE_FALL: num = nn - twop;
      mwsg_pkg::WAVE_TRI:  num = nn - (arise <<< 1);
      default:             num = '0;
    endcase
    mag = num[18] ? 17'(-num) : num[16:0];
    is_trig  = (wave_q == mwsg_pkg::WAVE_SIN) || (wave_q == mwsg_pkg::WAVE_COS);
    is_ratio = (wave_q == mwsg_pkg::WAVE_RISE) || (wave_q == mwsg_pkg::WAVE_FALL) ||
               (wave_q == mwsg_pkg::WAVE_TRI);
    if (is_trig)
      dividend = {p, 32'd0} + {33'd0, n[15:1]};
    else
      dividend = ({31'd0, mag} << mwsg_pkg::SAMPLE_FRAC) + {33'd0, n[15:1]};
  end

  logic                         div_done;
  logic [mwsg_pkg::QUOT_W-1:0]  quot;

  mwsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (is_trig || is_ratio)),
    .dividend_i (dividend),
    .divisor_i  (n),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // per-item work registers
  logic [2:0]  wave_w_q;
  logic        neg_q;
  logic [15:0] idx_w_q;
  logic        last_w_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wave_w_q <= wave_q;
      neg_q    <= num[18];
      idx_w_q  <= idx;
      last_w_q <= last;
    end
  end

  // CORDIC rotator, one iteration a cycle
  logic signed [mwsg_pkg::XY_W-1:0] x_q, y_q, dx, dy;
  logic signed [mwsg_pkg::Z_W-1:0]  z_q, z0, atan_s;
  logic [1:0]                       quad_q;
  logic [4:0]                       step_q;
  logic [32:0]                      qsum;

  always_comb begin
    qsum   = {1'b0, quot} + 33'h020000000;
    z0     = signed'({2'b00, quot}) - signed'({1'b0, qsum[32:30], 30'd0});
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    atan_s = signed'({2'b00, mwsg_pkg::atan_turns(step_q)});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      x_q    <= mwsg_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z0;
      quad_q <= qsum[31:30];
    end else if (state_q == ST_CORD) begin
      if (!z_q[mwsg_pkg::Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                    step_q <= '0;
    else if (state_q == ST_SETUP)   step_q <= '0;
    else if (state_q == ST_CORD)    step_q <= step_q + 5'd1;
  end

  // final sample: quadrant fold and rounding, signed ratio, or zero
  logic signed [mwsg_pkg::XY_W-1:0] cval, sval, pick, rnd;
  logic signed [63:0]               wide;
  logic signed [mwsg_pkg::SAMPLE_BITS-1:0] sample_fin;

  always_comb begin
    case (quad_q)
      2'd0:    begin cval = x_q;  sval = y_q;  end
      2'd1:    begin cval = -y_q; sval = x_q;  end
      2'd2:    begin cval = -x_q; sval = -y_q; end
      default: begin cval = y_q;  sval = -x_q; end
    endcase
    pick = (wave_w_q == mwsg_pkg::WAVE_COS) ? cval : sval;
    rnd  = (pick + (43'sd1 <<< (mwsg_pkg::ROUND_SHIFT - 1))) >>> mwsg_pkg::ROUND_SHIFT;
    case (wave_w_q)
      mwsg_pkg::WAVE_SIN, mwsg_pkg::WAVE_COS: wide = 64'(rnd);
      mwsg_pkg::WAVE_RISE, mwsg_pkg::WAVE_FALL, mwsg_pkg::WAVE_TRI:
        wide = neg_q ? -signed'({32'd0, quot}) : signed'({32'd0, quot});
      default: wide = '0;
    endcase
    sample_fin = mwsg_pkg::saturate(wide);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = (is_trig || is_ratio) ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_done) begin
        state_d = ((wave_w_q == mwsg_pkg::WAVE_SIN) || (wave_w_q == mwsg_pkg::WAVE_COS))
                  ? ST_SETUP : ST_FIN;
      end
      ST_SETUP: state_d = ST_CORD;
      ST_CORD:  if (step_q == 5'(mwsg_pkg::CORDIC_STEPS - 1)) state_d = ST_FIN;
      ST_FIN:   if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // output register
  logic load_out;
  assign load_out = (state_q == ST_FIN) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_o <= 1'b0;
    else if (load_out)      out_valid_o <= 1'b1;
    else if (out_ready_i)   out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sample_o        <= sample_fin;
      sample_index_o  <= idx_w_q;
      last_of_table_o <= last_w_q;
    end
  end

endmodule

### hdl/mwsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsg_div - bit-serial restoring divider
// One quotient bit per cycle; the dividend shifts out as the quotient
// shifts in. The quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module mwsg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mwsg_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [mwsg_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [mwsg_pkg::QUOT_W-1:0]     quot_o
);

  logic [mwsg_pkg::DIVISOR_W-1:0] rem_q, rem_d, div_q;
  logic [mwsg_pkg::QUOT_W-1:0]    sh_q, sh_d;
  logic [4:0]                     cnt_q, cnt_d;
  logic                           busy_q, busy_d, done_q, done_d;
  logic [mwsg_pkg::DIVISOR_W:0]   trial;
  logic [mwsg_pkg::DIVISOR_W:0]   diff;
  logic                           qbit;

  // one trial subtraction a cycle
  always_comb begin
    trial = {rem_q, sh_q[mwsg_pkg::QUOT_W-1]};
    diff  = trial - {1'b0, div_q};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = rem_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[mwsg_pkg::DIVIDEND_W-1:mwsg_pkg::QUOT_W];
      sh_d   = dividend_i[mwsg_pkg::QUOT_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? diff[mwsg_pkg::DIVISOR_W-1:0] : trial[mwsg_pkg::DIVISOR_W-1:0];
      sh_d  = {sh_q[mwsg_pkg::QUOT_W-2:0], qbit};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(mwsg_pkg::QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) div_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule
